/* hw/rtl/slvc_pkg.sv */
// ----------------------------------------------------------------------------
// slvc_pkg
// Shared constants, types and fixed-point helpers for the COSTALD volume core.
// ----------------------------------------------------------------------------
package slvc_pkg;

    localparam int FRAC      = 24;
    localparam int TEMP_W    = 24;
    localparam int VC_W      = 22;
    localparam int OMEGA_W   = 16;
    localparam int OMEGA_FRAC = 14;
    localparam int VOL_W     = 24;
    localparam int CFG_W     = 24;
    localparam int ADDR_W    = 2;

    localparam logic [ADDR_W-1:0] REG_CRIT_TEMP = 2'd0;
    localparam logic [ADDR_W-1:0] REG_CHAR_VOL  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_ACENTRIC  = 2'd2;

    localparam logic [TEMP_W-1:0] CRIT_TEMP_RESET = 24'd8388608;

    function automatic longint qk(input longint num);
        return ((num << FRAC) + 64'd5000000) / 64'd10000000;
    endfunction

    localparam logic [25:0] ONE   = 26'd1 << FRAC;
    localparam logic [25:0] K_A1  = 26'(qk(64'd15281600));
    localparam logic [25:0] K_A2  = 26'(qk(64'd14390700));
    localparam logic [25:0] K_A3  = 26'(qk(64'd8144600));
    localparam logic [25:0] K_A4  = 26'(qk(64'd1904540));
    localparam logic [25:0] K_B0  = 26'(qk(64'd2961230));
    localparam logic [25:0] K_B1  = 26'(qk(64'd3869140));
    localparam logic [25:0] K_B2  = 26'(qk(64'd427258));
    localparam logic [25:0] K_B3  = 26'(qk(64'd480645));
    localparam logic [25:0] K_DEN = 26'(qk(64'd10000100));

    localparam logic [32:0] VD_MAX = 33'd1 << 32;
    localparam logic [VOL_W-1:0] VOL_MAX = '1;

    typedef struct packed {
        logic        oor;
        logic [23:0] tr;
        logic [24:0] x;
        logic [25:0] v0;
        logic        neg;
    } meta_t;

    // floor(a * b / 2^FRAC); callers keep the product below 2^50
    function automatic logic [25:0] mulq(input logic [25:0] a, input logic [25:0] b);
        logic [51:0] p;
        p = {26'b0, a} * {26'b0, b};
        return p[FRAC+25:FRAC];
    endfunction

endpackage

/* hw/rtl/slvc_tr_div.sv */
// ----------------------------------------------------------------------------
// slvc_tr_div
// Pipelined restoring divider, one quotient bit per stage: tr = (t << 24) / Tc.
// ----------------------------------------------------------------------------
module slvc_tr_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [23:0]         in_num,
    input  logic [23:0]         divisor,
    input  slvc_pkg::meta_t     in_meta,
    output logic                out_valid,
    output logic [23:0]         out_quot,
    output slvc_pkg::meta_t     out_meta
);
    import slvc_pkg::*;

    localparam int STAGES = 24;

    logic        valid_reg [STAGES];
    logic [23:0] rem_reg   [STAGES];
    logic [23:0] quot_reg  [STAGES];
    meta_t       meta_reg  [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic [23:0] r_in;
            logic [23:0] q_in;
            logic        v_in;
            meta_t       m_in;
            logic [24:0] r2;
            logic [23:0] rem_next;
            logic [23:0] quot_next;

            if (s == 0) begin : g_first
                assign r_in = in_num;
                assign q_in = '0;
                assign v_in = in_valid;
                assign m_in = in_meta;
            end else begin : g_rest
                assign r_in = rem_reg[s-1];
                assign q_in = quot_reg[s-1];
                assign v_in = valid_reg[s-1];
                assign m_in = meta_reg[s-1];
            end

            assign r2 = {r_in, 1'b0};

            always_comb begin
                rem_next  = r2[23:0];
                quot_next = q_in;
                if (r2 >= {1'b0, divisor}) begin
                    rem_next = 24'(r2 - {1'b0, divisor});
                    quot_next[STAGES-1-s] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next;
                    quot_reg[s] <= quot_next;
                    meta_reg[s] <= m_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_meta  = meta_reg[STAGES-1];

endmodule

/* hw/rtl/slvc_cbrt.sv */
// ----------------------------------------------------------------------------
// slvc_cbrt
// Pipelined bitwise cube root of x in Q.24: 25 trial bits, two stages each.
// ----------------------------------------------------------------------------
module slvc_cbrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  slvc_pkg::meta_t     in_meta,
    output logic                out_valid,
    output logic [24:0]         out_root,
    output slvc_pkg::meta_t     out_meta
);
    import slvc_pkg::*;

    localparam int BITS = FRAC + 1;

    logic        a_valid_reg [BITS];
    logic [24:0] a_c_reg     [BITS];
    logic [24:0] a_t_reg     [BITS];
    logic [25:0] a_tt_reg    [BITS];
    meta_t       a_meta_reg  [BITS];

    logic        b_valid_reg [BITS];
    logic [24:0] b_c_reg     [BITS];
    meta_t       b_meta_reg  [BITS];

    genvar i;
    generate
        for (i = 0; i < BITS; i++) begin : g_bit
            logic [24:0] c_in;
            logic        v_in;
            meta_t       m_in;
            logic [24:0] t_next;
            logic [49:0] sq;
            logic [50:0] cube;
            logic [24:0] b_c_next;

            if (i == 0) begin : g_first
                assign c_in = '0;
                assign v_in = in_valid;
                assign m_in = in_meta;
            end else begin : g_rest
                assign c_in = b_c_reg[i-1];
                assign v_in = b_valid_reg[i-1];
                assign m_in = b_meta_reg[i-1];
            end

            assign t_next = c_in | (25'd1 << (BITS - 1 - i));
            assign sq     = {25'b0, t_next} * {25'b0, t_next};
            assign cube   = {25'b0, a_tt_reg[i]} * {26'b0, a_t_reg[i]};

            always_comb begin
                b_c_next = a_c_reg[i];
                if (cube[50:FRAC] <= {2'b0, a_meta_reg[i].x}) begin
                    b_c_next = a_t_reg[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    a_valid_reg[i] <= 1'b0;
                    b_valid_reg[i] <= 1'b0;
                end else if (en) begin
                    a_valid_reg[i] <= v_in;
                    b_valid_reg[i] <= a_valid_reg[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    a_c_reg[i]    <= c_in;
                    a_t_reg[i]    <= t_next;
                    a_tt_reg[i]   <= sq[49:FRAC];
                    a_meta_reg[i] <= m_in;
                    b_c_reg[i]    <= b_c_next;
                    b_meta_reg[i] <= a_meta_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = b_valid_reg[BITS-1];
    assign out_root  = b_c_reg[BITS-1];
    assign out_meta  = b_meta_reg[BITS-1];

endmodule

/* hw/rtl/slvc_vd_div.sv */
// ----------------------------------------------------------------------------
// slvc_vd_div
// Pipelined restoring divider for (mag << 24) / den, 33 quotient bits plus an
// early overflow flag for quotients of 2^33 and above.
// ----------------------------------------------------------------------------
module slvc_vd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [23:0]         in_mag,
    input  logic [24:0]         in_den,
    input  slvc_pkg::meta_t     in_meta,
    output logic                out_valid,
    output logic                out_big,
    output logic [32:0]         out_quot,
    output slvc_pkg::meta_t     out_meta
);
    import slvc_pkg::*;

    localparam int STAGES = 33;

    logic        valid_reg [STAGES];
    logic        big_reg   [STAGES];
    logic [24:0] rem_reg   [STAGES];
    logic [32:0] quot_reg  [STAGES];
    logic [23:0] mag_reg   [STAGES];
    logic [24:0] den_reg   [STAGES];
    meta_t       meta_reg  [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic [24:0] r_in;
            logic [32:0] q_in;
            logic        v_in;
            logic        big_in;
            logic [23:0] mag_in;
            logic [24:0] den_in;
            meta_t       m_in;
            logic        nb;
            logic [25:0] r2;
            logic [24:0] rem_next;
            logic [32:0] quot_next;

            if (s == 0) begin : g_first
                assign r_in   = {10'b0, in_mag[23:9]};
                assign q_in   = '0;
                assign v_in   = in_valid;
                assign big_in = {10'b0, in_mag[23:9]} >= in_den;
                assign mag_in = in_mag;
                assign den_in = in_den;
                assign m_in   = in_meta;
            end else begin : g_rest
                assign r_in   = rem_reg[s-1];
                assign q_in   = quot_reg[s-1];
                assign v_in   = valid_reg[s-1];
                assign big_in = big_reg[s-1];
                assign mag_in = mag_reg[s-1];
                assign den_in = den_reg[s-1];
                assign m_in   = meta_reg[s-1];
            end

            if (s <= 8) begin : g_bring
                assign nb = mag_in[8-s];
            end else begin : g_zero
                assign nb = 1'b0;
            end

            assign r2 = {r_in, nb};

            always_comb begin
                rem_next  = r2[24:0];
                quot_next = q_in;
                if (r2 >= {1'b0, den_in}) begin
                    rem_next = 25'(r2 - {1'b0, den_in});
                    quot_next[STAGES-1-s] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    big_reg[s]  <= big_in;
                    rem_reg[s]  <= rem_next;
                    quot_reg[s] <= quot_next;
                    mag_reg[s]  <= mag_in;
                    den_reg[s]  <= den_in;
                    meta_reg[s] <= m_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign out_big   = big_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_meta  = meta_reg[STAGES-1];

endmodule

/* hw/rtl/saturated_liquid_volume_costald_core.sv */
// ----------------------------------------------------------------------------
// saturated_liquid_volume_costald_core
// COSTALD saturated liquid molar volume, one temperature in, one volume out.
//
//   channel | dir | ports                          | payload
//   s_      | in  | s_tvalid s_tready s_tdata      | temperature
//   m_      | out | m_tvalid m_tready m_tdata/tuser| volume, range and clip flags
//   cfg_    | in  | cfg_wr_en cfg_addr cfg_wr_data | Tc, Vc, omega
//
// One item per cycle while m_ is not stalled; the pipeline holds the 24-stage tr divider,
// the 50-stage cube root and the 33-stage Vd divider.
// aresetn is synchronous; it clears all valid bits and resets the config registers.
// A stall on m_ freezes the whole pipeline and drops s_tready in that cycle.
// ----------------------------------------------------------------------------
module saturated_liquid_volume_costald_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // [23:0] temperature
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [23:0] liquid_volume
    output logic [1:0]                    m_tuser,   // [0] out_of_range, [1] saturated
    input  logic                          cfg_wr_en,
    input  logic [slvc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [slvc_pkg::CFG_W-1:0]    cfg_wr_data
);
    import slvc_pkg::*;

    logic [TEMP_W-1:0]   tc_reg;
    logic [VC_W-1:0]     vc_reg;
    logic [OMEGA_W-1:0]  omega_reg;
    logic                en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg    <= CRIT_TEMP_RESET;
            vc_reg    <= '0;
            omega_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CRIT_TEMP: tc_reg    <= cfg_wr_data[TEMP_W-1:0];
                REG_CHAR_VOL:  vc_reg    <= cfg_wr_data[VC_W-1:0];
                REG_ACENTRIC:  omega_reg <= cfg_wr_data[OMEGA_W-1:0];
                default: ;
            endcase
        end
    end

    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // input stage
    logic        in_valid_reg;
    logic [23:0] t_reg;
    logic        oor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= s_tdata;
            oor_reg <= (s_tdata >= tc_reg);
        end
    end

    meta_t       div_meta_in;
    logic        trd_valid;
    logic [23:0] trd_quot;
    meta_t       trd_meta;

    always_comb begin
        div_meta_in     = '0;
        div_meta_in.oor = oor_reg;
    end

    slvc_tr_div u_tr_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_num    (oor_reg ? 24'd0 : t_reg),
        .divisor   (tc_reg),
        .in_meta   (div_meta_in),
        .out_valid (trd_valid),
        .out_quot  (trd_quot),
        .out_meta  (trd_meta)
    );

    // x = 1 - tr
    logic  x_valid_reg;
    meta_t x_meta_reg;
    meta_t x_meta_next;

    always_comb begin
        x_meta_next    = trd_meta;
        x_meta_next.tr = trd_quot;
        x_meta_next.x  = 25'(ONE - {2'b0, trd_quot});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
        end else if (en) begin
            x_valid_reg <= trd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_meta_reg <= x_meta_next;
        end
    end

    logic        cb_valid;
    logic [24:0] cb_root;
    meta_t       cb_meta;

    slvc_cbrt u_cbrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x_valid_reg),
        .in_meta   (x_meta_reg),
        .out_valid (cb_valid),
        .out_root  (cb_root),
        .out_meta  (cb_meta)
    );

    // polynomial stages
    logic        p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    meta_t       p1_meta_reg, p2_meta_reg, p3_meta_reg, p4_meta_reg;
    logic [25:0] p1_a1_reg, p1_cc_reg, p1_a3_reg, p1_xc_reg, p1_tr2_reg, p1_b1_reg;
    logic [25:0] p2_a1_reg, p2_a2_reg, p2_a3_reg, p2_a4_reg, p2_tr3_reg;
    logic [25:0] p2_b1_reg, p2_b2_reg;
    logic [25:0] p3_v0_reg, p3_b1_reg, p3_b3_reg;
    logic [27:0] p3_nneg_reg;
    logic [23:0] p4_mag_reg;
    logic [24:0] p4_den_reg;

    logic [27:0] v0_pos, v0_negs;
    logic [27:0] num_negs;
    logic [27:0] num_mag;
    meta_t       p4_meta_next;

    assign v0_pos   = 28'(ONE) + 28'(p2_a2_reg) + 28'(p2_a4_reg);
    assign v0_negs  = 28'(p2_a1_reg) + 28'(p2_a3_reg);
    assign num_negs = p3_nneg_reg + 28'(p3_b3_reg);
    assign num_mag  = (28'(p3_b1_reg) > num_negs) ? 28'(p3_b1_reg) - num_negs
                                                   : num_negs - 28'(p3_b1_reg);

    always_comb begin
        p4_meta_next     = p3_meta_reg;
        p4_meta_next.v0  = p3_v0_reg;
        p4_meta_next.neg = 28'(p3_b1_reg) > num_negs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= cb_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_meta_reg <= cb_meta;
            p1_a1_reg   <= mulq(K_A1, {1'b0, cb_root});
            p1_cc_reg   <= mulq({1'b0, cb_root}, {1'b0, cb_root});
            p1_a3_reg   <= mulq(K_A3, {1'b0, cb_meta.x});
            p1_xc_reg   <= mulq({1'b0, cb_meta.x}, {1'b0, cb_root});
            p1_tr2_reg  <= mulq({2'b0, cb_meta.tr}, {2'b0, cb_meta.tr});
            p1_b1_reg   <= mulq(K_B1, {2'b0, cb_meta.tr});

            p2_meta_reg <= p1_meta_reg;
            p2_a1_reg   <= p1_a1_reg;
            p2_a2_reg   <= mulq(K_A2, p1_cc_reg);
            p2_a3_reg   <= p1_a3_reg;
            p2_a4_reg   <= mulq(K_A4, p1_xc_reg);
            p2_tr3_reg  <= mulq(p1_tr2_reg, {2'b0, p1_meta_reg.tr});
            p2_b1_reg   <= p1_b1_reg;
            p2_b2_reg   <= mulq(K_B2, p1_tr2_reg);

            p3_meta_reg <= p2_meta_reg;
            p3_v0_reg   <= (v0_pos > v0_negs) ? 26'(v0_pos - v0_negs) : 26'd0;
            p3_b1_reg   <= p2_b1_reg;
            p3_b3_reg   <= mulq(K_B3, p2_tr3_reg);
            p3_nneg_reg <= 28'(K_B0) + 28'(p2_b2_reg);

            p4_meta_reg <= p4_meta_next;
            p4_mag_reg  <= (num_mag >= 28'(ONE)) ? 24'hFFFFFF : num_mag[23:0];
            p4_den_reg  <= 25'(K_DEN - {2'b0, p3_meta_reg.tr});
        end
    end

    logic        vd_valid;
    logic        vd_big;
    logic [32:0] vd_quot;
    meta_t       vd_meta;

    slvc_vd_div u_vd_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_mag    (p4_mag_reg),
        .in_den    (p4_den_reg),
        .in_meta   (p4_meta_reg),
        .out_valid (vd_valid),
        .out_big   (vd_big),
        .out_quot  (vd_quot),
        .out_meta  (vd_meta)
    );

    // scaling stages
    logic        v1_valid_reg, v2_valid_reg, v3_valid_reg;
    meta_t       v1_meta_reg, v2_meta_reg, v3_meta_reg;
    logic [32:0] v1_vd_reg;
    logic [33:0] v2_factor_reg;
    logic [35:0] v3_tq_reg;

    logic        om_neg;
    logic [15:0] om_mag;
    logic [48:0] om_prod;
    logic [33:0] prod;
    logic [59:0] tq_prod;
    logic [57:0] vol_prod;
    logic [33:0] vol;

    assign om_neg   = omega_reg[OMEGA_W-1];
    assign om_mag   = om_neg ? 16'(-omega_reg) : omega_reg;
    assign om_prod  = {33'b0, om_mag} * {16'b0, v1_vd_reg};
    assign prod     = om_prod[OMEGA_FRAC+33:OMEGA_FRAC];
    assign tq_prod  = {34'b0, v2_meta_reg.v0} * {26'b0, v2_factor_reg};
    assign vol_prod = {36'b0, vc_reg} * {22'b0, v3_tq_reg};
    assign vol      = vol_prod[FRAC+33:FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            v1_valid_reg <= vd_valid;
            v2_valid_reg <= v1_valid_reg;
            v3_valid_reg <= v2_valid_reg;
            m_valid_reg  <= v3_valid_reg;
        end
    end

    logic [23:0] m_data_reg;
    logic        m_oor_reg;
    logic        m_sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_meta_reg <= vd_meta;
            v1_vd_reg   <= (vd_big || vd_quot > VD_MAX) ? VD_MAX : vd_quot;

            v2_meta_reg <= v1_meta_reg;
            if (om_neg != v1_meta_reg.neg) begin
                v2_factor_reg <= 34'(ONE) + prod;
            end else if (prod > 34'(ONE)) begin
                v2_factor_reg <= '0;
            end else begin
                v2_factor_reg <= 34'(ONE) - prod;
            end

            v3_meta_reg <= v2_meta_reg;
            v3_tq_reg   <= tq_prod[FRAC+35:FRAC];

            if (v3_meta_reg.oor) begin
                m_data_reg <= '0;
                m_oor_reg  <= 1'b1;
                m_sat_reg  <= 1'b0;
            end else if (vol > 34'(VOL_MAX)) begin
                m_data_reg <= VOL_MAX;
                m_oor_reg  <= 1'b0;
                m_sat_reg  <= 1'b1;
            end else begin
                m_data_reg <= vol[23:0];
                m_oor_reg  <= 1'b0;
                m_sat_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_sat_reg, m_oor_reg};

`ifndef NO_ASSERTIONS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("out_of_range and saturated both set");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("out_of_range item carries a nonzero volume");

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == VOL_MAX))
        else $error("saturated item not at full scale");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(v3_valid_reg) && $stable(p1_valid_reg)))
        else $error("pipeline advanced during a stall");
`endif

endmodule
